[src/bir_pkg.sv]
// ----------------------------------------------------------------------------
// bir_pkg
// Shared constants, codes and types of the bilinear image resizer.
// ----------------------------------------------------------------------------
package bir_pkg;

	localparam int MAX_SRC_WIDTH  = 64;
	localparam int MAX_SRC_HEIGHT = 64;
	localparam int MAX_CHANNELS   = 4;
	localparam int MAX_DST_DIM    = 4096;

	localparam int CH_W       = 8;
	localparam int FRAC_W     = 16;
	localparam int NUM_OUT_CH = 4;

	localparam int SRC_MAX   = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ? MAX_SRC_WIDTH
	                                                            : MAX_SRC_HEIGHT;
	localparam int SRC_IDX_W = $clog2(SRC_MAX);
	localparam int COORD_W   = $clog2(MAX_DST_DIM);

	localparam int CFG_SRC_W  = 7;
	localparam int CFG_DST_W  = 13;
	localparam int CFG_CH_W   = 3;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 3;

	localparam int STEP_W    = SRC_IDX_W + FRAC_W;
	localparam int POS_W     = COORD_W + STEP_W;
	localparam int DIV_CNT_W = $clog2(STEP_W + 1);
	localparam int WORD_W    = CH_W * MAX_CHANNELS;
	localparam int BLEND_W   = CH_W + FRAC_W;

	localparam int BANK_COLS  = (MAX_SRC_WIDTH + 1) / 2;
	localparam int BANK_ROWS  = (MAX_SRC_HEIGHT + 1) / 2;
	localparam int BANK_DEPTH = BANK_COLS * BANK_ROWS;
	localparam int BANK_AW    = $clog2(BANK_DEPTH);
	localparam int NUM_BANKS  = 4;

	localparam logic [CFG_SRC_W-1:0] RST_SRC_SIZE  = CFG_SRC_W'(64);
	localparam logic [CFG_DST_W-1:0] RST_DST_SIZE  = CFG_DST_W'(64);
	localparam logic [CFG_CH_W-1:0]  RST_CHANNELS  = CFG_CH_W'(4);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH,
		REG_SRC_HEIGHT,
		REG_DST_WIDTH,
		REG_DST_HEIGHT,
		REG_CHANNEL_COUNT
	} cfg_reg_e;

	typedef enum logic {
		OP_LOAD,
		OP_EMIT
	} op_e;

	typedef struct packed {
		logic en_s3;
		logic en_s4;
	} lane_ctl_t;

endpackage

[src/bir_ram.sv]
// ----------------------------------------------------------------------------
// bir_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bir_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/bir_step_div.sv]
// ----------------------------------------------------------------------------
// bir_step_div
// Radix-2 restoring divider for the 6.16 sampling step of one axis.
// ----------------------------------------------------------------------------
module bir_step_div import bir_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 restart,
	input  logic [CFG_SRC_W-1:0] src_size,
	input  logic [CFG_DST_W-1:0] dst_size,
	output logic [STEP_W-1:0]    step,
	output logic                 busy
);

	logic                 pend_q;
	logic                 run_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [STEP_W-1:0]    step_q;
	logic [STEP_W-1:0]    quo_q;
	logic [COORD_W-1:0]   rem_q;
	logic [COORD_W-1:0]   den_q;
	logic                 zero_q;

	logic [CFG_SRC_W-1:0] src_m1;
	logic [CFG_DST_W-1:0] dst_m1;
	logic [COORD_W:0]     trial;
	logic [COORD_W:0]     diff;
	logic                 q_bit;
	logic [STEP_W-1:0]    quo_nx;
	logic [COORD_W-1:0]   rem_nx;

	always_comb begin
		src_m1 = src_size - CFG_SRC_W'(1);
		dst_m1 = dst_size - CFG_DST_W'(1);
		trial  = {rem_q, quo_q[STEP_W-1]};
		diff   = trial - {1'b0, den_q};
		q_bit  = (trial >= {1'b0, den_q});
		rem_nx = q_bit ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
		quo_nx = {quo_q[STEP_W-2:0], q_bit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b1;
			run_q  <= 1'b0;
			cnt_q  <= '0;
			step_q <= '0;
		end else begin
			pend_q <= restart;
			if (pend_q) begin
				run_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(STEP_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					run_q  <= 1'b0;
					step_q <= zero_q ? '0 : quo_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q) begin
			quo_q  <= {src_m1[SRC_IDX_W-1:0], {FRAC_W{1'b0}}};
			rem_q  <= '0;
			den_q  <= dst_m1[COORD_W-1:0];
			zero_q <= (dst_m1 == '0);
		end else if (run_q) begin
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end
	end

	assign step = step_q;
	assign busy = pend_q || run_q;

endmodule

[src/bir_axis.sv]
// ----------------------------------------------------------------------------
// bir_axis
// Sample position of one axis: registered coordinate times step, then split
// into clamped floor and ceil indices and a 16-bit fraction.
// ----------------------------------------------------------------------------
module bir_axis import bir_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic [COORD_W-1:0]   coord,
	input  logic [STEP_W-1:0]    step,
	input  logic [CFG_SRC_W-1:0] size,
	output logic [SRC_IDX_W-1:0] lo,
	output logic [SRC_IDX_W-1:0] hi,
	output logic [FRAC_W-1:0]    frac
);

	localparam int FL_W = POS_W - FRAC_W;

	logic [POS_W-1:0]     pos_s1;
	logic [FL_W-1:0]      fl;
	logic [FRAC_W-1:0]    fr;
	logic [FL_W:0]        ce;
	logic [FL_W:0]        lim_w;
	logic [FL_W:0]        lo_w;
	logic [FL_W:0]        hi_w;
	logic [CFG_SRC_W-1:0] lim;

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1 <= POS_W'(coord) * POS_W'(step);
		end
	end

	always_comb begin
		fl    = pos_s1[POS_W-1:FRAC_W];
		fr    = pos_s1[FRAC_W-1:0];
		ce    = {1'b0, fl} + {{FL_W{1'b0}}, (fr != '0)};
		lim   = size - CFG_SRC_W'(1);
		lim_w = (FL_W + 1)'(lim);
		lo_w  = ({1'b0, fl} > lim_w) ? lim_w : {1'b0, fl};
		hi_w  = (ce > lim_w) ? lim_w : ce;
		lo    = lo_w[SRC_IDX_W-1:0];
		hi    = hi_w[SRC_IDX_W-1:0];
		frac  = fr;
	end

endmodule

[src/bir_lane.sv]
// ----------------------------------------------------------------------------
// bir_lane
// One channel lane: horizontal blend of both rows, then vertical blend,
// truncated to 8 bits.
// ----------------------------------------------------------------------------
module bir_lane import bir_pkg::*; (
	input  logic              clk,
	input  lane_ctl_t         ctl,
	input  logic [CH_W-1:0]   a,
	input  logic [CH_W-1:0]   b,
	input  logic [CH_W-1:0]   d,
	input  logic [CH_W-1:0]   e,
	input  logic [FRAC_W-1:0] tx,
	input  logic [FRAC_W-1:0] ty,
	output logic [CH_W-1:0]   result
);

	localparam int HP_W = CH_W + FRAC_W + 2;
	localparam int VP_W = BLEND_W + FRAC_W + 2;

	logic [BLEND_W-1:0] top_s3;
	logic [BLEND_W-1:0] bot_s3;
	logic [FRAC_W-1:0]  ty_s3;
	logic [CH_W-1:0]    res_s4;

	logic signed [CH_W:0]    dab;
	logic signed [CH_W:0]    dde;
	logic signed [HP_W-1:0]  sab;
	logic signed [HP_W-1:0]  sde;
	logic signed [BLEND_W:0] dtb;
	logic signed [VP_W-1:0]  sv;

	always_comb begin
		dab = $signed({1'b0, b}) - $signed({1'b0, a});
		dde = $signed({1'b0, e}) - $signed({1'b0, d});
		sab = $signed({2'b00, a, {FRAC_W{1'b0}}}) + dab * $signed({1'b0, tx});
		sde = $signed({2'b00, d, {FRAC_W{1'b0}}}) + dde * $signed({1'b0, tx});
		dtb = $signed({1'b0, bot_s3}) - $signed({1'b0, top_s3});
		sv  = $signed({2'b00, top_s3, {FRAC_W{1'b0}}}) + dtb * $signed({1'b0, ty_s3});
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			top_s3 <= sab[BLEND_W-1:0];
			bot_s3 <= sde[BLEND_W-1:0];
			ty_s3  <= ty;
		end
		if (ctl.en_s4) begin
			res_s4 <= sv[2*FRAC_W+CH_W-1:2*FRAC_W];
		end
	end

	assign result = res_s4;

endmodule

[src/bir_merge.sv]
// ----------------------------------------------------------------------------
// bir_merge
// Merges lane results into the output word: masks unused channels and
// out-of-range pixels, and holds the word until the consumer takes it.
// ----------------------------------------------------------------------------
module bir_merge import bir_pkg::*; (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             valid_s4,
	input  logic                             oob_s4,
	input  logic [CFG_CH_W-1:0]              nch,
	input  logic [NUM_OUT_CH-1:0][CH_W-1:0]  lane_val,
	input  logic                             out_stall,
	output logic                             ready,
	output logic                             out_valid,
	output logic [CH_W-1:0]                  out_ch0,
	output logic [CH_W-1:0]                  out_ch1,
	output logic [CH_W-1:0]                  out_ch2,
	output logic [CH_W-1:0]                  out_ch3,
	output logic                             status
);

	logic                            vo_q;
	logic [NUM_OUT_CH-1:0][CH_W-1:0] ch_q;
	logic                            status_q;
	logic [NUM_OUT_CH-1:0][CH_W-1:0] ch_nx;

	always_comb begin
		for (int c = 0; c < NUM_OUT_CH; c++) begin
			ch_nx[c] = (!oob_s4 && (c < int'(nch))) ? lane_val[c] : '0;
		end
	end

	assign ready = !vo_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else if (ready) begin
			vo_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid_s4) begin
			ch_q     <= ch_nx;
			status_q <= oob_s4;
		end
	end

	assign out_valid = vo_q;
	assign out_ch0   = ch_q[0];
	assign out_ch1   = ch_q[1];
	assign out_ch2   = ch_q[2];
	assign out_ch3   = ch_q[3];
	assign status    = status_q;

endmodule

[src/bilinear_image_resizer.sv]
// ----------------------------------------------------------------------------
// bilinear_image_resizer
// Corner-aligned bilinear scaler with a parity-banked texel store and one
// blend lane per channel.
//
//   channel  handshake            payload
//   config   wr_en                wr_index, wr_data
//   input    in_valid / in_stall  op, texel_x, texel_y, in_ch0..3, dst_col, dst_row
//   output   out_valid / out_stall out_ch0..3, status
//
// One word per cycle unless stalled; an emit passes the position, bank-read,
// horizontal-blend, vertical-blend and output registers in turn. The four
// texel banks each give one neighbour per cycle unless stalled. After reset
// and after every config write the input stalls while the step dividers run,
// one quotient bit per cycle. The texel store is not cleared by reset. Output
// stalls back up through the pipeline stages; loads produce no output word.
// ----------------------------------------------------------------------------
module bilinear_image_resizer import bir_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  op,
	input  logic [SRC_IDX_W-1:0]  texel_x,
	input  logic [SRC_IDX_W-1:0]  texel_y,
	input  logic [CH_W-1:0]       in_ch0,
	input  logic [CH_W-1:0]       in_ch1,
	input  logic [CH_W-1:0]       in_ch2,
	input  logic [CH_W-1:0]       in_ch3,
	input  logic [COORD_W-1:0]    dst_col,
	input  logic [COORD_W-1:0]    dst_row,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CH_W-1:0]       out_ch0,
	output logic [CH_W-1:0]       out_ch1,
	output logic [CH_W-1:0]       out_ch2,
	output logic [CH_W-1:0]       out_ch3,
	output logic                  status
);

	function automatic logic [BANK_AW-1:0] bank_addr(input logic [SRC_IDX_W-1:0] x,
	                                                 input logic [SRC_IDX_W-1:0] y);
		bank_addr = BANK_AW'(y[SRC_IDX_W-1:1] * BANK_COLS) + BANK_AW'(x[SRC_IDX_W-1:1]);
	endfunction

	logic [CFG_SRC_W-1:0] src_width_q;
	logic [CFG_SRC_W-1:0] src_height_q;
	logic [CFG_DST_W-1:0] dst_width_q;
	logic [CFG_DST_W-1:0] dst_height_q;
	logic [CFG_CH_W-1:0]  channel_count_q;

	logic [CFG_SRC_W-1:0] sw_c;
	logic [CFG_SRC_W-1:0] sh_c;
	logic [CFG_DST_W-1:0] dw_c;
	logic [CFG_DST_W-1:0] dh_c;
	logic [CFG_CH_W-1:0]  nch_c;

	logic [STEP_W-1:0] col_step;
	logic [STEP_W-1:0] row_step;
	logic              col_busy;
	logic              row_busy;

	logic acc;
	logic acc_emit;
	logic acc_load;
	logic load_in_rng;
	logic oob_in;

	logic ready1;
	logic ready2;
	logic ready3;
	logic ready4;
	logic ready_o;

	logic v1_q;
	logic v2_q;
	logic v3_q;
	logic v4_q;
	logic oob_s1;
	logic oob_s2;
	logic oob_s3;
	logic oob_s4;

	logic [SRC_IDX_W-1:0] x_lo;
	logic [SRC_IDX_W-1:0] x_hi;
	logic [SRC_IDX_W-1:0] y_lo;
	logic [SRC_IDX_W-1:0] y_hi;
	logic [FRAC_W-1:0]    x_frac;
	logic [FRAC_W-1:0]    y_frac;

	logic [FRAC_W-1:0] tx_s2;
	logic [FRAC_W-1:0] ty_s2;
	logic              xf0_s2;
	logic              xc0_s2;
	logic              yf0_s2;
	logic              yc0_s2;

	logic [WORD_W-1:0] wr_word;
	logic [BANK_AW-1:0] wr_addr;
	logic [NUM_BANKS-1:0][WORD_W-1:0] bank_rd;
	logic [WORD_W-1:0] t00;
	logic [WORD_W-1:0] t10;
	logic [WORD_W-1:0] t01;
	logic [WORD_W-1:0] t11;

	lane_ctl_t                        lane_ctl;
	logic [NUM_OUT_CH-1:0][CH_W-1:0]  lane_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q     <= RST_SRC_SIZE;
			src_height_q    <= RST_SRC_SIZE;
			dst_width_q     <= RST_DST_SIZE;
			dst_height_q    <= RST_DST_SIZE;
			channel_count_q <= RST_CHANNELS;
		end else if (wr_en) begin
			case (cfg_reg_e'(wr_index))
				REG_SRC_WIDTH:     src_width_q     <= wr_data[CFG_SRC_W-1:0];
				REG_SRC_HEIGHT:    src_height_q    <= wr_data[CFG_SRC_W-1:0];
				REG_DST_WIDTH:     dst_width_q     <= wr_data[CFG_DST_W-1:0];
				REG_DST_HEIGHT:    dst_height_q    <= wr_data[CFG_DST_W-1:0];
				REG_CHANNEL_COUNT: channel_count_q <= wr_data[CFG_CH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		sw_c = (src_width_q == '0) ? CFG_SRC_W'(1) :
		       (src_width_q > CFG_SRC_W'(MAX_SRC_WIDTH)) ? CFG_SRC_W'(MAX_SRC_WIDTH)
		                                                  : src_width_q;
		sh_c = (src_height_q == '0) ? CFG_SRC_W'(1) :
		       (src_height_q > CFG_SRC_W'(MAX_SRC_HEIGHT)) ? CFG_SRC_W'(MAX_SRC_HEIGHT)
		                                                    : src_height_q;
		dw_c = (dst_width_q == '0) ? CFG_DST_W'(1) :
		       (dst_width_q > CFG_DST_W'(MAX_DST_DIM)) ? CFG_DST_W'(MAX_DST_DIM)
		                                                : dst_width_q;
		dh_c = (dst_height_q == '0) ? CFG_DST_W'(1) :
		       (dst_height_q > CFG_DST_W'(MAX_DST_DIM)) ? CFG_DST_W'(MAX_DST_DIM)
		                                                 : dst_height_q;
		nch_c = (channel_count_q == '0) ? CFG_CH_W'(1) :
		        (channel_count_q > CFG_CH_W'(MAX_CHANNELS)) ? CFG_CH_W'(MAX_CHANNELS)
		                                                     : channel_count_q;
	end

	bir_step_div u_col_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (wr_en),
		.src_size (sw_c),
		.dst_size (dw_c),
		.step     (col_step),
		.busy     (col_busy)
	);

	bir_step_div u_row_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (wr_en),
		.src_size (sh_c),
		.dst_size (dh_c),
		.step     (row_step),
		.busy     (row_busy)
	);

	// back-pressure chain, one stage at a time
	assign ready4 = !v4_q || ready_o;
	assign ready3 = !v3_q || ready4;
	assign ready2 = !v2_q || ready3;
	assign ready1 = !v1_q || ready2;

	assign in_stall    = !ready1 || col_busy || row_busy || wr_en;
	assign acc         = in_valid && !in_stall;
	assign acc_emit    = acc && (op == OP_EMIT);
	assign acc_load    = acc && (op == OP_LOAD);
	assign load_in_rng = (int'(texel_x) < MAX_SRC_WIDTH) && (int'(texel_y) < MAX_SRC_HEIGHT);
	assign oob_in      = ({1'b0, dst_col} >= dw_c) || ({1'b0, dst_row} >= dh_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (ready1) v1_q <= acc_emit;
			if (ready2) v2_q <= v1_q;
			if (ready3) v3_q <= v2_q;
			if (ready4) v4_q <= v3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ready1) begin
			oob_s1 <= oob_in;
		end
		if (ready2) begin
			oob_s2 <= oob_s1;
			tx_s2  <= x_frac;
			ty_s2  <= y_frac;
			xf0_s2 <= x_lo[0];
			xc0_s2 <= x_hi[0];
			yf0_s2 <= y_lo[0];
			yc0_s2 <= y_hi[0];
		end
		if (ready3) begin
			oob_s3 <= oob_s2;
		end
		if (ready4) begin
			oob_s4 <= oob_s3;
		end
	end

	bir_axis u_axis_x (
		.clk   (clk),
		.en    (ready1),
		.coord (dst_col),
		.step  (col_step),
		.size  (sw_c),
		.lo    (x_lo),
		.hi    (x_hi),
		.frac  (x_frac)
	);

	bir_axis u_axis_y (
		.clk   (clk),
		.en    (ready1),
		.coord (dst_row),
		.step  (row_step),
		.size  (sh_c),
		.lo    (y_lo),
		.hi    (y_hi),
		.frac  (y_frac)
	);

	assign wr_word = WORD_W'({in_ch3, in_ch2, in_ch1, in_ch0});
	assign wr_addr = bank_addr(texel_x, texel_y);

	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		localparam int PX = b % 2;
		localparam int PY = b / 2;
		logic                 we;
		logic [SRC_IDX_W-1:0] xs;
		logic [SRC_IDX_W-1:0] ys;

		assign we = acc_load && load_in_rng &&
		            (texel_x[0] == PX[0]) && (texel_y[0] == PY[0]);
		assign xs = (x_lo[0] == PX[0]) ? x_lo : x_hi;
		assign ys = (y_lo[0] == PY[0]) ? y_lo : y_hi;

		bir_ram #(
			.WIDTH (WORD_W),
			.DEPTH (BANK_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (we),
			.waddr (wr_addr),
			.wdata (wr_word),
			.re    (ready2),
			.raddr (bank_addr(xs, ys)),
			.rdata (bank_rd[b])
		);
	end

	assign t00 = bank_rd[{yf0_s2, xf0_s2}];
	assign t10 = bank_rd[{yf0_s2, xc0_s2}];
	assign t01 = bank_rd[{yc0_s2, xf0_s2}];
	assign t11 = bank_rd[{yc0_s2, xc0_s2}];

	assign lane_ctl.en_s3 = ready3;
	assign lane_ctl.en_s4 = ready4;

	for (genvar c = 0; c < NUM_OUT_CH; c++) begin : g_lane
		if (c < MAX_CHANNELS) begin : g_on
			bir_lane u_lane (
				.clk    (clk),
				.ctl    (lane_ctl),
				.a      (t00[c*CH_W +: CH_W]),
				.b      (t10[c*CH_W +: CH_W]),
				.d      (t01[c*CH_W +: CH_W]),
				.e      (t11[c*CH_W +: CH_W]),
				.tx     (tx_s2),
				.ty     (ty_s2),
				.result (lane_val[c])
			);
		end else begin : g_off
			assign lane_val[c] = '0;
		end
	end

	bir_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s4  (v4_q),
		.oob_s4    (oob_s4),
		.nch       (nch_c),
		.lane_val  (lane_val),
		.out_stall (out_stall),
		.ready     (ready_o),
		.out_valid (out_valid),
		.out_ch0   (out_ch0),
		.out_ch1   (out_ch1),
		.out_ch2   (out_ch2),
		.out_ch3   (out_ch3),
		.status    (status)
	);

	a_oob_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |->
			(out_ch0 == '0 && out_ch1 == '0 && out_ch2 == '0 && out_ch3 == '0))
		else $error("out-of-range pixel carries nonzero channels");

	a_x_neighbors: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q |-> ((x_hi - x_lo) <= SRC_IDX_W'(1)))
		else $error("column ceil index not floor or floor plus one");

	a_y_neighbors: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q |-> ((y_hi - y_lo) <= SRC_IDX_W'(1)))
		else $error("row ceil index not floor or floor plus one");

	a_ch3_masked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (nch_c <= CFG_CH_W'(3)) && $stable(nch_c) |-> out_ch3 == '0)
		else $error("channel beyond channel count not zero");

endmodule
